/* sv/sapava_pkg.sv */
`default_nettype none
package sapava_pkg;
   localparam int MaxPoints = 32;
   localparam int PosW = 5;
   localparam int EndW = 6;
   localparam int WtW = 16;
   localparam int PobsW = 24;
   localparam int WsumW = 21;
   localparam int OsumW = 30;
   localparam int FitW = 17;
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_ADD = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_RSVD = 2'd3;
   localparam logic [PobsW-1:0] OBS_MAX = {PobsW{1'b1}};
   localparam logic [FitW-1:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic start;
      logic [OsumW-1:0] num;
      logic [WsumW-1:0] den;
   } div_req_type;
endpackage
`default_nettype wire

/* sv/sapava_div.sv */
`default_nettype none
// Restoring divider: floor(num*65536/den), saturated at 1.0; one quotient bit a cycle.
module sapava_div (
   input wire logic clock,
   input wire logic reset,
   input wire sapava_pkg::div_req_type req,
   output logic busy,
   output logic [sapava_pkg::FitW-1:0] quot
);
   localparam int NumW = sapava_pkg::OsumW + 16;
   localparam int RemW = sapava_pkg::WsumW + 1;
   logic [NumW-1:0] num_ff, num_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [sapava_pkg::WsumW-1:0] den_ff, den_in;
   logic [NumW-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [RemW-1:0] trial;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[RemW-2:0], num_ff[NumW-1]};
      if (req.start) begin
         num_in = {req.num, 16'd0};
         den_in = req.den;
         rem_in = '0;
         q_in = '0;
         cnt_in = 6'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff <= q_in;
   end

   assign busy = busy_ff;
   always_comb begin
      if (den_ff == '0) quot = '0;
      else if (q_ff > NumW'(sapava_pkg::ONE_Q16)) quot = sapava_pkg::ONE_Q16;
      else quot = q_ff[sapava_pkg::FitW-1:0];
   end
endmodule
`default_nettype wire

/* sv/sequential_antitonic_pava_unit.sv */
`default_nettype none
// Antitonic pool-adjacent-violators fit over up to 32 positions, one item at a time.
// A load is accepted and then runs a clearing sweep over the sums. An add scans or
// copies one block at a time, sums or re-places one position at a time, and does
// each cross-multiplied mean compare in CMP0 then CMP1 (the merge shares CMP1); one
// shared 30x21 multiplier does each compare. A read emits one value per position,
// holding it while the receiver stalls; each new block adds a 46-step bit-serial
// division. Config writes also take the clearing sweep before the next transaction.
module sequential_antitonic_pava_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_func,
   input wire logic [4:0] req_position,
   input wire logic [15:0] req_amount,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [4:0] rsp_out_position,
   output logic [16:0] rsp_fit_value,
   output logic rsp_last,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [5:0] csr_size_in_use
);
   localparam int N = sapava_pkg::MaxPoints;
   localparam int IW = sapava_pkg::EndW;
   localparam int WW = sapava_pkg::WsumW;
   localparam int OW = sapava_pkg::OsumW;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_FIND, S_TAILCP, S_SUM, S_PLACE, S_CMP0, S_CMP1,
      S_NEXTPT, S_TAILBK, S_RD_BLK, S_RD_DIV, S_RD_WAIT, S_RD_OUT
   } state_type;

   state_type state_ff;
   logic [WW-1:0] pw [N];
   logic [sapava_pkg::PobsW-1:0] po [N];
   logic [IW-1:0] be [N];
   logic [WW-1:0] bw [N];
   logic [OW-1:0] bo [N];
   logic [IW-1:0] te [N];
   logic [WW-1:0] tw [N];
   logic [OW-1:0] to [N];
   logic [IW-1:0] size_ff, cnt_ff, i_ff, s_ff, d_ff, tn_ff, b_ff, k_ff;
   logic [4:0] j_ff;
   logic [WW-1:0] ws_ff;
   logic [OW-1:0] os_ff;
   logic [OW+WW-1:0] left_ff;
   logic [4:0] p_ff;
   logic [16:0] fit_ff;
   logic last_ff, rv_ff;
   sapava_pkg::div_req_type dreq;
   logic dbusy;
   logic [16:0] dq;
   logic [OW+WW-1:0] prod;
   logic [OW-1:0] mo;
   logic [WW-1:0] mw;
   logic [IW-1:0] m_used, dm1;
   logic [IW:0] nsz;
   logic cmp_le;

   assign dm1 = d_ff - 1'b1;
   assign m_used = size_ff;
   assign prod = mo * mw;
   assign cmp_le = left_ff <= prod;
   // a config write takes the idle slot, so hold off the request side
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_out_position = p_ff;
   assign rsp_fit_value = fit_ff;
   assign rsp_last = last_ff;

   // shared multiplier operand select: CMP0 forms obs[d-1]*w[d], CMP1 obs[d]*w[d-1]
   always_comb begin
      if (state_ff == S_CMP0) begin
         mo = bo[dm1[4:0]];
         mw = bw[d_ff[4:0]];
      end else begin
         mo = bo[d_ff[4:0]];
         mw = bw[dm1[4:0]];
      end
   end

   always_comb begin
      if (csr_size_in_use == 6'd0) nsz = 7'd1;
      else if (csr_size_in_use > 6'(N)) nsz = 7'(N);
      else nsz = {1'b0, csr_size_in_use};
   end

   assign dreq.start = (state_ff == S_RD_DIV);
   assign dreq.num = bo[k_ff[4:0]];
   assign dreq.den = bw[k_ff[4:0]];

   sapava_div u_div (
      .clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quot(dq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         size_ff <= 6'(N);
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (rv_ff && !rsp_stall && state_ff != S_RD_OUT) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  size_ff <= nsz[IW-1:0];
                  cnt_ff <= '0;
                  state_ff <= S_CLEAR;
               end else if (req_valid) begin
                  j_ff <= req_position;
                  case (req_func)
                     sapava_pkg::FUNC_LOAD: begin
                        pw[req_position] <= (req_amount == 16'd0) ? WW'(1)
                                           : WW'(req_amount);
                        cnt_ff <= '0;
                        state_ff <= S_CLEAR;
                     end
                     sapava_pkg::FUNC_ADD: begin
                        if ({1'b0, req_position} < m_used) begin
                           po[req_position] <=
                              (25'(po[req_position]) + 25'(req_amount) > 25'(sapava_pkg::OBS_MAX))
                              ? sapava_pkg::OBS_MAX : po[req_position] + 24'(req_amount);
                           s_ff <= '0;
                           state_ff <= S_FIND;
                        end
                     end
                     sapava_pkg::FUNC_READ: begin
                        k_ff <= '0;
                        i_ff <= '0;
                        state_ff <= S_RD_DIV;
                     end
                     default: ;
                  endcase
               end
            end
            S_CLEAR: begin
               // sweep: clear one position's sums per cycle
               po[cnt_ff[4:0]] <= '0;
               bw[cnt_ff[4:0]] <= '0;
               bo[cnt_ff[4:0]] <= '0;
               be[cnt_ff[4:0]] <= (cnt_ff == '0) ? m_used - 1'b1 : '0;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'(N - 1)) begin
                  d_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_FIND: begin
               if (s_ff + 1'b1 <= d_ff && be[s_ff[4:0]] < {1'b0, j_ff})
                  s_ff <= s_ff + 1'b1;
               else begin
                  b_ff <= (be[s_ff[4:0]] < {1'b0, j_ff}) ? {1'b0, j_ff} : be[s_ff[4:0]];
                  i_ff <= s_ff + 1'b1;
                  tn_ff <= '0;
                  state_ff <= S_TAILCP;
               end
            end
            S_TAILCP: begin
               if (i_ff <= d_ff) begin
                  te[tn_ff[4:0]] <= be[i_ff[4:0]];
                  tw[tn_ff[4:0]] <= bw[i_ff[4:0]];
                  to[tn_ff[4:0]] <= bo[i_ff[4:0]];
                  tn_ff <= tn_ff + 1'b1;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  i_ff <= (s_ff == '0) ? '0 : be[s_ff[4:0] - 5'd1] + 1'b1;
                  ws_ff <= '0;
                  os_ff <= '0;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               if (i_ff <= {1'b0, j_ff}) begin
                  ws_ff <= ws_ff + pw[i_ff[4:0]];
                  os_ff <= os_ff + OW'(po[i_ff[4:0]]);
                  i_ff <= i_ff + 1'b1;
               end else begin
                  be[s_ff[4:0]] <= {1'b0, j_ff};
                  bw[s_ff[4:0]] <= ws_ff;
                  bo[s_ff[4:0]] <= os_ff;
                  d_ff <= s_ff;
                  i_ff <= {1'b0, j_ff} + 1'b1;
                  state_ff <= S_CMP0;
               end
            end
            S_CMP0: begin
               if (d_ff == '0) state_ff <= S_NEXTPT;
               else begin
                  left_ff <= prod;
                  state_ff <= S_CMP1;
               end
            end
            S_CMP1: begin
               if (cmp_le) begin
                  bw[dm1[4:0]] <= bw[dm1[4:0]] + bw[d_ff[4:0]];
                  bo[dm1[4:0]] <= bo[dm1[4:0]] + bo[d_ff[4:0]];
                  be[dm1[4:0]] <= be[d_ff[4:0]];
                  d_ff <= dm1;
                  state_ff <= S_CMP0;
               end else state_ff <= S_NEXTPT;
            end
            S_NEXTPT: begin
               if (i_ff <= b_ff) begin
                  be[d_ff[4:0] + 5'd1] <= i_ff;
                  bw[d_ff[4:0] + 5'd1] <= pw[i_ff[4:0]];
                  bo[d_ff[4:0] + 5'd1] <= OW'(po[i_ff[4:0]]);
                  d_ff <= d_ff + 1'b1;
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_CMP0;
               end else begin
                  k_ff <= '0;
                  state_ff <= S_TAILBK;
               end
            end
            S_TAILBK: begin
               if (k_ff < tn_ff && d_ff + 1'b1 < 6'(N)) begin
                  be[d_ff[4:0] + 5'd1] <= te[k_ff[4:0]];
                  bw[d_ff[4:0] + 5'd1] <= tw[k_ff[4:0]];
                  bo[d_ff[4:0] + 5'd1] <= to[k_ff[4:0]];
                  d_ff <= d_ff + 1'b1;
                  k_ff <= k_ff + 1'b1;
               end else state_ff <= S_IDLE;
            end
            S_RD_DIV: state_ff <= S_RD_WAIT;
            S_RD_WAIT: if (!dbusy) state_ff <= S_RD_OUT;
            S_RD_OUT: begin
               if (!rv_ff || !rsp_stall) begin
                  rv_ff <= 1'b1;
                  p_ff <= i_ff[4:0];
                  fit_ff <= dq;
                  last_ff <= (i_ff + 1'b1 == m_used);
                  i_ff <= i_ff + 1'b1;
                  if (i_ff + 1'b1 == m_used) state_ff <= S_IDLE;
                  else if (k_ff < d_ff && be[k_ff[4:0]] <= i_ff) begin
                     k_ff <= k_ff + 1'b1;
                     state_ff <= S_RD_BLK;
                  end
               end
            end
            S_RD_BLK: begin
               if (k_ff < d_ff && be[k_ff[4:0]] < i_ff) k_ff <= k_ff + 1'b1;
               else state_ff <= S_RD_DIV;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> req_stall;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_fit_value));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("stalled result changed");

   property p_fit_range;
      @(posedge clock) disable iff (reset) rsp_valid |-> (rsp_fit_value <= 17'h10000);
   endproperty
   a_fit_range: assert property (p_fit_range) else $error("fit above one");
endmodule
`default_nettype wire

/* tb/sapava_checker.sv */
`default_nettype none
module sapava_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic [1:0] req_func,
   input wire logic [4:0] req_position,
   input wire logic [15:0] req_amount,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [4:0] rsp_out_position,
   input wire logic [16:0] rsp_fit_value,
   input wire logic rsp_last,
   input wire logic csr_valid,
   input wire logic csr_ready,
   input wire logic [5:0] csr_size_in_use,
   output int fail_count,
   output int pending
);
   typedef struct packed {
      logic [sapava_pkg::PosW-1:0] pos;
      logic [sapava_pkg::FitW-1:0] fit;
      logic last;
   } fit_entry_type;

   fit_entry_type fit_queue[$];

   logic [sapava_pkg::WtW-1:0] pt_weight[sapava_pkg::MaxPoints];
   logic [sapava_pkg::PobsW-1:0] pt_obs[sapava_pkg::MaxPoints];
   int unsigned blk_end[sapava_pkg::MaxPoints];
   int unsigned blk_wsum[sapava_pkg::MaxPoints];
   int unsigned blk_osum[sapava_pkg::MaxPoints];
   int unsigned blk_count;
   int unsigned size_reg;

   function automatic int unsigned fit_size();
      if (size_reg < 1) return 1;
      if (size_reg > sapava_pkg::MaxPoints) return sapava_pkg::MaxPoints;
      return size_reg;
   endfunction

   function automatic void restart_fit();
      for (int i = 0; i < sapava_pkg::MaxPoints; i++) begin
         pt_obs[i] = '0;
         blk_end[i] = 0;
         blk_wsum[i] = 0;
         blk_osum[i] = 0;
      end
      blk_end[0] = fit_size() - 1;
      blk_count = 1;
   endfunction

   function automatic bit mean_not_above(int unsigned lo, int unsigned hi);
      longint unsigned l, r;
      l = longint'(blk_osum[lo]) * longint'(blk_wsum[hi]);
      r = longint'(blk_osum[hi]) * longint'(blk_wsum[lo]);
      return l <= r;
   endfunction

   // merge the top block downward while means fail to strictly decrease
   function automatic int unsigned pool_down(int unsigned d);
      while (d >= 1 && mean_not_above(d - 1, d)) begin
         blk_wsum[d-1] = (blk_wsum[d-1] + blk_wsum[d]) & 32'h1F_FFFF;
         blk_osum[d-1] = (blk_osum[d-1] + blk_osum[d]) & 32'h3FFF_FFFF;
         blk_end[d-1] = blk_end[d];
         d--;
      end
      return d;
   endfunction

   function automatic void add_obs(int unsigned j, int unsigned amt);
      int unsigned t_end[sapava_pkg::MaxPoints], t_w[sapava_pkg::MaxPoints];
      int unsigned t_o[sapava_pkg::MaxPoints];
      int unsigned s, a, b, d, tn, ws, os, v;
      s = 0; tn = 0; ws = 0; os = 0;
      v = pt_obs[j] + amt;
      pt_obs[j] = (v > sapava_pkg::OBS_MAX) ? sapava_pkg::OBS_MAX
                                            : v[sapava_pkg::PobsW-1:0];
      while (s + 1 < blk_count && blk_end[s] < j) s++;
      a = (s == 0) ? 0 : blk_end[s-1] + 1;
      b = blk_end[s];
      if (b < j) b = j;
      for (int unsigned i = s + 1; i < blk_count && i < sapava_pkg::MaxPoints; i++) begin
         t_end[tn] = blk_end[i];
         t_w[tn] = blk_wsum[i];
         t_o[tn] = blk_osum[i];
         tn++;
      end
      for (int unsigned i = a; i <= j && i < sapava_pkg::MaxPoints; i++) begin
         ws += pt_weight[i];
         os += pt_obs[i];
      end
      blk_end[s] = j;
      blk_wsum[s] = ws & 32'h1F_FFFF;
      blk_osum[s] = os & 32'h3FFF_FFFF;
      d = pool_down(s);
      for (int unsigned i = j + 1; i <= b && i < sapava_pkg::MaxPoints; i++) begin
         d++;
         blk_end[d] = i;
         blk_wsum[d] = pt_weight[i];
         blk_osum[d] = pt_obs[i];
         d = pool_down(d);
      end
      for (int unsigned i = 0; i < tn && d + 1 < sapava_pkg::MaxPoints; i++) begin
         d++;
         blk_end[d] = t_end[i];
         blk_wsum[d] = t_w[i];
         blk_osum[d] = t_o[i];
      end
      blk_count = d + 1;
   endfunction

   function automatic void predict_fit();
      int unsigned n, k;
      longint unsigned q;
      fit_entry_type e;
      n = fit_size();
      k = 0;
      for (int unsigned p = 0; p < n; p++) begin
         while (k + 1 < blk_count && blk_end[k] < p) k++;
         if (blk_wsum[k] == 0) q = 0;
         else q = (longint'(blk_osum[k]) << 16) / longint'(blk_wsum[k]);
         if (q > sapava_pkg::ONE_Q16) q = sapava_pkg::ONE_Q16;
         e.pos = p[sapava_pkg::PosW-1:0];
         e.fit = q[sapava_pkg::FitW-1:0];
         e.last = (p + 1 == n);
         fit_queue = {fit_queue, e};
      end
   endfunction

   always @(posedge clock) begin
      fit_entry_type e;
      if (reset) begin
         size_reg = 32;
         for (int i = 0; i < sapava_pkg::MaxPoints; i++) pt_weight[i] = '0;
         restart_fit();
         fit_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (fit_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: pos %0d fit %0d last %0d",
                     rsp_out_position, rsp_fit_value, rsp_last);
            end else begin
               e = fit_queue.pop_front();
               if (rsp_out_position !== e.pos || rsp_fit_value !== e.fit
                     || rsp_last !== e.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp pos %0d fit %0d last %0d, got %0d %0d %0d",
                        e.pos, e.fit, e.last, rsp_out_position, rsp_fit_value, rsp_last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            size_reg = 32'(csr_size_in_use);
            restart_fit();
         end
         if (req_valid && !req_stall) begin
            case (req_func)
               sapava_pkg::FUNC_LOAD: begin
                  pt_weight[req_position] = (req_amount == 0) ? 16'd1 : req_amount;
                  restart_fit();
               end
               sapava_pkg::FUNC_ADD:
                  if (req_position < fit_size()) add_obs(req_position, req_amount);
               sapava_pkg::FUNC_READ: predict_fit();
               default: ;
            endcase
         end
      end
      pending <= fit_queue.size();
   end
endmodule
`default_nettype wire

/* tb/tb_sequential_antitonic_pava_unit.sv */
`default_nettype none
module tb_sequential_antitonic_pava_unit;
   localparam int SettleCycles = 800;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic [1:0] req_func;
   logic [4:0] req_position;
   logic [15:0] req_amount;
   logic rsp_valid, rsp_stall, rsp_last;
   logic [4:0] rsp_out_position;
   logic [16:0] rsp_fit_value;
   logic csr_valid, csr_ready;
   logic [5:0] csr_size_in_use;
   int fail_count, pending;
   bit quiet;
   int stall_left;

   sequential_antitonic_pava_unit u_dut (.*);

   sapava_checker u_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[sequential_antitonic_pava_unit] ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver backpressure: short stalls mostly, occasional long one
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(0, 3);
      end
   end

   task automatic send(input logic [1:0] f, input logic [4:0] p, input logic [15:0] a);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_position <= p;
      req_amount <= a;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_size(input logic [5:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_size_in_use <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_amount();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_phase(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 10)
            send(sapava_pkg::FUNC_LOAD, 5'($urandom_range(0, 31)), rand_amount());
         else if (r < 72)
            send(sapava_pkg::FUNC_ADD, 5'($urandom_range(0, 31)), rand_amount());
         else if (r < 94)
            send(sapava_pkg::FUNC_READ, 5'($urandom_range(0, 31)),
                 16'($urandom_range(0, 65535)));
         else
            send(sapava_pkg::FUNC_RSVD, 5'($urandom_range(0, 31)),
                 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      logic [5:0] sizes[6];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= sapava_pkg::FUNC_LOAD;
      req_position <= '0;
      req_amount <= '0;
      csr_valid <= 1'b0;
      csr_size_in_use <= '0;
      quiet = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero weight sums read back as zero
      send(sapava_pkg::FUNC_READ, 5'd0, 16'd0);
      for (int p = 0; p < sapava_pkg::MaxPoints; p++)
         send(sapava_pkg::FUNC_LOAD, p[4:0], (p == 3) ? 16'd0 : (p == 9) ? 16'hFFFF
                                  : 16'($urandom_range(1, 65535)));
      send(sapava_pkg::FUNC_ADD, 5'd0, 16'hFFFF);
      send(sapava_pkg::FUNC_ADD, 5'd31, 16'hFFFF);
      send(sapava_pkg::FUNC_ADD, 5'd3, 16'd0);
      send(sapava_pkg::FUNC_ADD, 5'd12, 16'h8000);
      send(sapava_pkg::FUNC_RSVD, 5'd31, 16'hFFFF);
      send(sapava_pkg::FUNC_READ, 5'd31, 16'hFFFF);
      send(sapava_pkg::FUNC_READ, 5'd0, 16'd0);
      send(sapava_pkg::FUNC_LOAD, 5'd7, 16'h1234);
      send(sapava_pkg::FUNC_READ, 5'd0, 16'd0);

      sizes[0] = 6'd1;
      sizes[1] = 6'd0;
      sizes[2] = 6'd63;
      sizes[3] = 6'd32;
      sizes[4] = 6'($urandom_range(2, 31));
      sizes[5] = 6'($urandom_range(1, 63));
      for (int k = 0; k < 6; k++) begin
         write_size(sizes[k]);
         quiet = (k == 3);
         send(sapava_pkg::FUNC_ADD, 5'd31, 16'd100);
         send(sapava_pkg::FUNC_READ, 5'd0, 16'd0);
         random_phase(18);
      end
      quiet = 1'b0;

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("[sequential_antitonic_pava_unit] OK");
      end else begin
         $display("[sequential_antitonic_pava_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
sv/sapava_pkg.sv
sv/sapava_div.sv
sv/sequential_antitonic_pava_unit.sv
tb/sapava_checker.sv
tb/tb_sequential_antitonic_pava_unit.sv
